// ----- rtl/core/nearest_neighbour_line_scaler_defines.svh -----
// ---------------------------------------------------------------------------
// Nearest-neighbour line scaler: assertion macros
// Shared property shorthands for the scaler modules. They expect signals
// named clk and arst_n in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOUR_LINE_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOUR_LINE_SCALER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NNLS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define NNLS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/nnls_pkg.sv -----
// ---------------------------------------------------------------------------
// Nearest-neighbour line scaler package
// Command and status codes, register indexes and the result descriptor
// passed from the control unit to the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

package nnls_pkg;

	localparam int unsigned PIX_W   = 24;
	localparam int unsigned INW_W   = 13;
	localparam int unsigned OUTW_W  = 16;
	localparam int unsigned SCALE_W = 23;
	localparam int unsigned FRAC_W  = 24;
	localparam int unsigned POS_W   = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 23;

	localparam logic [FRAC_W-1:0] Q_ONE = 24'h01_0000;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_FETCH = 2'd1,
		CMD_START = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_LOADED  = 2'd0,
		ST_PIXEL   = 2'd1,
		ST_SPENT   = 2'd2,
		ST_REFUSED = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = 2'd2;

	typedef struct packed {
		status_t status;
		logic    row_end;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/core/nearest_neighbour_line_scaler.sv -----
// ---------------------------------------------------------------------------
// Nearest-neighbour line scaler
// Top level: control unit, line store RAM and output stage.
// ---------------------------------------------------------------------------
// Takes one item per clock (load, fetch, start or none) and answers each
// with one result. A result passes through the registered read of the line
// store RAM and then the output register.
// Loads write the line store, fetches read it at the scaled column; all frame
// state updates in the accept cycle, so back-to-back items need no stall.
// in_ready drops only when the output register is full and not being taken.
// The line store has no clear pass; only entries written this row are read.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_neighbour_line_scaler #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [nnls_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [nnls_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         cmd,
	input  wire logic [nnls_pkg::PIX_W-1:0]         pixel_in,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [1:0]                              status,
	output logic [nnls_pkg::PIX_W-1:0]              pixel_out,
	output logic                                    row_end
);

	import nnls_pkg::*;

	localparam int unsigned AW = $clog2(MAX_WIDTH);

	logic             acc;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [PIX_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [PIX_W-1:0] mem_rdata;
	result_t          res;

	assign acc = in_valid && in_ready;

	nnls_ctrl #(
		.MAX_WIDTH(MAX_WIDTH),
		.AW       (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.acc      (acc),
		.cmd      (cmd),
		.pixel_in (pixel_in),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.res      (res)
	);

	nnls_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	nnls_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (acc),
		.res      (res),
		.rdata    (mem_rdata),
		.take     (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.pixel_out(pixel_out),
		.row_end  (row_end)
	);

endmodule

`default_nettype wire

// ----- rtl/core/nnls_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while the
// read enable is low.
// ---------------------------------------------------------------------------
`default_nettype none

module nnls_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/nnls_ctrl.sv -----
// ---------------------------------------------------------------------------
// Nearest-neighbour line scaler: control unit
// Holds the configuration and frame state, decodes each accepted item and
// issues the line store write or read for it.
// ---------------------------------------------------------------------------
`default_nettype none

module nnls_ctrl #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned AW        = $clog2(MAX_WIDTH)
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [nnls_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [nnls_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                               acc,
	input  wire logic [1:0]                         cmd,
	input  wire logic [nnls_pkg::PIX_W-1:0]         pixel_in,
	output logic                                    mem_we,
	output logic [AW-1:0]                           mem_waddr,
	output logic [nnls_pkg::PIX_W-1:0]              mem_wdata,
	output logic                                    mem_re,
	output logic [AW-1:0]                           mem_raddr,
	output nnls_pkg::result_t                       res
);

	import nnls_pkg::*;

	localparam logic [14:0] MAXW_L = 15'(MAX_WIDTH);

	logic [INW_W-1:0]   in_width_q;
	logic [OUTW_W-1:0]  out_width_q;
	logic [SCALE_W-1:0] inv_scale_q;

	logic [INW_W-1:0]  wc_q, wc_d;
	logic              rr_q, rr_d;
	logic [FRAC_W-1:0] rf_q, rf_d;
	logic [OUTW_W-1:0] oc_q, oc_d;
	logic [POS_W-1:0]  cp_q, cp_d;

	logic [INW_W-1:0]  eff_in;
	logic [OUTW_W-1:0] eff_out;
	logic [INW_W-1:0]  wc_inc;
	logic [OUTW_W-1:0] oc_inc;
	logic [POS_W:0]    cp_sum;
	logic [15:0]       col_idx;
	logic [15:0]       col_lim;
	logic [15:0]       col_sel;
	logic              store_ok;
	logic              we_c;
	logic              re_c;
	cmd_t              cmd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= INW_W'(1);
			out_width_q <= OUTW_W'(1);
			inv_scale_q <= SCALE_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IN_WIDTH:  in_width_q  <= cfg_wdata[INW_W-1:0];
				REG_OUT_WIDTH: out_width_q <= cfg_wdata[OUTW_W-1:0];
				REG_INV_SCALE: inv_scale_q <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// A width of zero acts as one; an input width above the store is capped.
	assign eff_in  = (in_width_q == '0) ? INW_W'(1) :
		(({2'b00, in_width_q} > MAXW_L) ? MAXW_L[INW_W-1:0] : in_width_q);
	assign eff_out = (out_width_q == '0) ? OUTW_W'(1) : out_width_q;

	assign wc_inc   = wc_q + INW_W'(1);
	assign oc_inc   = oc_q + OUTW_W'(1);
	assign cp_sum   = {1'b0, cp_q} + {10'b0, inv_scale_q};
	assign col_idx  = cp_q[POS_W-1:16];
	assign col_lim  = {3'b000, eff_in} - 16'd1;
	assign col_sel  = (col_idx > col_lim) ? col_lim : col_idx;
	assign store_ok = ({2'b00, wc_q} < MAXW_L);
	assign cmd_c    = cmd_t'(cmd);

	always_comb begin
		wc_d = wc_q;
		rr_d = rr_q;
		rf_d = rf_q;
		oc_d = oc_q;
		cp_d = cp_q;
		we_c = 1'b0;
		re_c = 1'b0;
		res.status  = ST_LOADED;
		res.row_end = 1'b0;
		unique case (cmd_c)
			CMD_LOAD: begin
				if (rr_q) begin
					res.status = ST_REFUSED;
				end else begin
					we_c = store_ok;
					wc_d = wc_inc;
					if (wc_inc >= eff_in) begin
						rr_d = 1'b1;
						oc_d = '0;
						cp_d = '0;
					end
				end
			end
			CMD_FETCH: begin
				if (!rr_q) begin
					res.status = ST_SPENT;
				end else if (rf_q >= Q_ONE) begin
					// row used up: drop one unit and ask for the next row
					res.status = ST_SPENT;
					rf_d = rf_q - Q_ONE;
					rr_d = 1'b0;
					wc_d = '0;
				end else begin
					res.status = ST_PIXEL;
					re_c = 1'b1;
					cp_d = cp_sum[POS_W] ? '1 : cp_sum[POS_W-1:0];
					oc_d = oc_inc;
					if (oc_inc == '0 || oc_inc >= eff_out) begin
						res.row_end = 1'b1;
						oc_d = '0;
						cp_d = '0;
						rf_d = rf_q + {1'b0, inv_scale_q};
					end
				end
			end
			CMD_START: begin
				wc_d = '0;
				rr_d = 1'b0;
				rf_d = '0;
				oc_d = '0;
				cp_d = '0;
			end
			CMD_NONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
			rr_q <= 1'b0;
			rf_q <= '0;
			oc_q <= '0;
			cp_q <= '0;
		end else if (acc) begin
			wc_q <= wc_d;
			rr_q <= rr_d;
			rf_q <= rf_d;
			oc_q <= oc_d;
			cp_q <= cp_d;
		end
	end

	assign mem_we    = acc && we_c;
	assign mem_waddr = AW'(wc_q);
	assign mem_wdata = pixel_in;
	assign mem_re    = acc && re_c;
	assign mem_raddr = col_sel[AW-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/nnls_out.sv -----
// ---------------------------------------------------------------------------
// Nearest-neighbour line scaler: output stage
// Tracks the item whose line store read is in flight and registers the
// finished result so the input side keeps moving while the output stalls, until the in-flight slot is full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nearest_neighbour_line_scaler_defines.svh"

module nnls_out (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        issue,
	input  wire nnls_pkg::result_t           res,
	input  wire logic [nnls_pkg::PIX_W-1:0]  rdata,
	output logic                             take,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [1:0]                       status,
	output logic [nnls_pkg::PIX_W-1:0]       pixel_out,
	output logic                             row_end
);

	import nnls_pkg::*;

	logic            valid_s1;
	result_t         res_s1;
	logic            out_valid_q;
	status_t         status_q;
	logic [PIX_W-1:0] pixel_q;
	logic            row_end_q;
	logic            out_free;

	assign out_free = !out_valid_q || out_ready;
	assign take     = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= issue;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && issue) begin
			res_s1 <= res;
		end
		if (out_free && valid_s1) begin
			status_q  <= res_s1.status;
			row_end_q <= res_s1.row_end;
			// only a pixel result carries line store data
			pixel_q   <= (res_s1.status == ST_PIXEL) ? rdata : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pixel_out = pixel_q;
	assign row_end   = row_end_q;

	`NNLS_ASSERT_IMP(a_pix_only_on_pixel, out_valid_q && status_q != ST_PIXEL, pixel_q == '0, "pixel data on a non-pixel result")
	`NNLS_ASSERT_IMP(a_row_end_on_pixel, out_valid_q && row_end_q, status_q == ST_PIXEL, "row end on a non-pixel result")
	`NNLS_ASSERT_NXT(a_s1_holds, valid_s1 && !out_free, valid_s1 && $stable(res_s1), "in-flight item lost while output stalled")

endmodule

`default_nettype wire
